FILE: hw/rtl/text_to_pixel_character_generator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character generator
// Shared property forms; every user has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_PIXEL_CHARACTER_GENERATOR_CORE_MACROS_SVH
`define TEXT_TO_PIXEL_CHARACTER_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define TPCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// plain invariant
`define TPCG_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

FILE: hw/rtl/tpcg_pkg.sv
// ----------------------------------------------------------------------------
// tpcg_pkg
// Constants, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tpcg_pkg;

  localparam int GLYPH_STORE_DEPTH = 512;
  localparam int CELL_WIDTH        = 6;
  localparam int LINE_PITCH        = 10;

  localparam int XW = 12;
  localparam int YW = 11;
  localparam int CW = 8;   // color width
  localparam int GAW = 9;  // glyph_addr port width
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 12;

  localparam int FIRST_CHAR   = 32;
  localparam int LAST_CHAR    = 127;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_ROWS   = 8;
  localparam int NEWLINE_CODE = 10;

  localparam logic OP_TEXT  = 1'b0;
  localparam logic OP_GLYPH = 1'b1;

  localparam logic [CFG_IW-1:0] REG_COLOR_LIMIT   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DEFAULT_COLOR = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BLANK_COLOR   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CLIP_ENABLE   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CLIP_COLUMN   = 3'd4;

  localparam logic [CW-1:0] RST_COLOR_LIMIT   = 8'd7;
  localparam logic [CW-1:0] RST_DEFAULT_COLOR = 8'd7;
  localparam logic [CW-1:0] RST_BLANK_COLOR   = 8'd0;

  typedef struct packed {
    logic accept;    // take the input word
    logic col_load;  // fetch glyph column, restart row count
    logic col_adv;   // step to next cell column
    logic emit;      // load one pixel into the output register
    logic done;      // cell finished, advance cursor
  } tpcg_cmd_t;

  typedef struct packed {
    logic draw;      // word at input draws a cell
    logic col_end;   // all cell columns visited
    logic col_skip;  // column clipped away
    logic row_last;  // bottom row of column
    logic out_free;  // output register can take a pixel
  } tpcg_sts_t;

endpackage

FILE: hw/rtl/text_to_pixel_character_generator_core.sv
// ----------------------------------------------------------------------------
// text_to_pixel_character_generator_core
// Character generator: text bytes in, pixel writes of a 5x8 font out.
// ----------------------------------------------------------------------------
// Glyph writes, color codes and newlines are taken in the idle state and
// start no cell walk. For a drawn character the sequencer visits each
// cell column in turn: it reads the glyph store for the column, then emits
// the 8 pixel words of that column, one per row, holding while the output
// is stalled; a clipped-away column is skipped. The output register lets the
// next input word be taken while the final pixel word still waits.
module text_to_pixel_character_generator_core #(
  parameter int GLYPH_STORE_DEPTH = tpcg_pkg::GLYPH_STORE_DEPTH,
  parameter int CELL_WIDTH        = tpcg_pkg::CELL_WIDTH,
  parameter int LINE_PITCH        = tpcg_pkg::LINE_PITCH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpcg_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [tpcg_pkg::CFG_DW-1:0]       cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [7:0]                        in_text_byte,
  input  logic                              in_start_of_text,
  input  logic signed [tpcg_pkg::XW-1:0]    in_origin_x,
  input  logic signed [tpcg_pkg::YW-1:0]    in_origin_y,
  input  logic [tpcg_pkg::GAW-1:0]          in_glyph_addr,
  input  logic [7:0]                        in_glyph_data,
  // pixel words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tpcg_pkg::XW-1:0]    out_pixel_x,
  output logic signed [tpcg_pkg::YW-1:0]    out_pixel_y,
  output logic [tpcg_pkg::CW-1:0]           out_pixel_color,
  output logic                              out_last
);

  tpcg_pkg::tpcg_cmd_t cmd;
  tpcg_pkg::tpcg_sts_t sts;

  assign cfg_ready = 1'b1;

  tpcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpcg_dp #(
    .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH),
    .CELL_WIDTH        (CELL_WIDTH),
    .LINE_PITCH        (LINE_PITCH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_opcode),
    .in_text_byte     (in_text_byte),
    .in_start_of_text (in_start_of_text),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_glyph_addr    (in_glyph_addr),
    .in_glyph_data    (in_glyph_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_color  (out_pixel_color),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

FILE: hw/rtl/tpcg_ctrl.sv
// ----------------------------------------------------------------------------
// tpcg_ctrl
// Sequencer: accepts one word, then for a drawn character walks cell columns and rows.
// ----------------------------------------------------------------------------
module tpcg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpcg_pkg::tpcg_sts_t sts,
  output tpcg_pkg::tpcg_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COL,
    ST_ROW
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.draw) state_nxt = ST_COL;
        end
      end
      ST_COL: begin
        if (sts.col_end) begin
          cmd.done  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.col_skip) begin
          cmd.col_adv = 1'b1;
        end else begin
          cmd.col_load = 1'b1;
          state_nxt    = ST_ROW;
        end
      end
      ST_ROW: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.row_last) begin
            cmd.col_adv = 1'b1;
            state_nxt   = ST_COL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `include "text_to_pixel_character_generator_core_macros.svh"

  `TPCG_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.accept, cmd.col_load, cmd.emit, cmd.done}), "conflicting commands")
  `TPCG_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "pixel emitted into a full output register")
  `TPCG_ASSERT_NEXT(a_load_then_row, cmd.col_load, state_r == ST_ROW, "column fetch not followed by rows")

endmodule

FILE: hw/rtl/tpcg_dp.sv
// ----------------------------------------------------------------------------
// tpcg_dp
// Config registers, cursor and color state, glyph store, pixel output register.
// ----------------------------------------------------------------------------
module tpcg_dp #(
  parameter int GLYPH_STORE_DEPTH = tpcg_pkg::GLYPH_STORE_DEPTH,
  parameter int CELL_WIDTH        = tpcg_pkg::CELL_WIDTH,
  parameter int LINE_PITCH        = tpcg_pkg::LINE_PITCH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tpcg_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [tpcg_pkg::CFG_DW-1:0]         cfg_data,
  // input word
  input  logic                                in_opcode,
  input  logic [7:0]                          in_text_byte,
  input  logic                                in_start_of_text,
  input  logic [tpcg_pkg::XW-1:0]             in_origin_x,
  input  logic [tpcg_pkg::YW-1:0]             in_origin_y,
  input  logic [tpcg_pkg::GAW-1:0]            in_glyph_addr,
  input  logic [7:0]                          in_glyph_data,
  // output word
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tpcg_pkg::XW-1:0]             out_pixel_x,
  output logic [tpcg_pkg::YW-1:0]             out_pixel_y,
  output logic [tpcg_pkg::CW-1:0]             out_pixel_color,
  output logic                                out_last,
  // control
  input  tpcg_pkg::tpcg_cmd_t                 cmd,
  output tpcg_pkg::tpcg_sts_t                 sts
);

  localparam int AW = $clog2(GLYPH_STORE_DEPTH);
  localparam int KW = $clog2(CELL_WIDTH + 1);
  localparam int RW = $clog2(tpcg_pkg::GLYPH_ROWS);
  localparam int XW = tpcg_pkg::XW;
  localparam int YW = tpcg_pkg::YW;
  localparam int CW = tpcg_pkg::CW;

  // config
  logic [CW-1:0] color_limit_r, default_color_r, blank_color_r;
  logic          clip_en_r;
  logic [XW-1:0] clip_col_r;

  // text state
  logic [XW-1:0] cursor_x_r, cursor_x_nxt;
  logic [YW-1:0] cursor_y_r, cursor_y_nxt;
  logic [XW-1:0] line_x_r, line_x_nxt;
  logic [CW-1:0] color_r, color_nxt;
  logic [7:0]    ch_r;

  // cell walk
  logic [KW-1:0] k_r;
  logic [RW-1:0] row_r;
  logic [7:0]    col_bits_r;
  logic          col_glyph_r;

  logic [7:0]    glyph_mem [0:GLYPH_STORE_DEPTH-1];

  logic          out_valid_r;
  logic [XW-1:0] px_r;
  logic [YW-1:0] py_r;
  logic [CW-1:0] pc_r;
  logic          last_r;

  logic          is_color, is_newline;
  logic [XW-1:0] px;
  logic          ch_in_range;
  logic [7:0]    char_off;
  logic [tpcg_pkg::GAW-1:0] glyph_base;
  logic [AW-1:0] rd_addr;
  logic          pix_set;

  // ---- input decode ----
  assign is_color   = (in_text_byte <= color_limit_r);
  assign is_newline = (in_text_byte == 8'(tpcg_pkg::NEWLINE_CODE));

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    line_x_nxt   = line_x_r;
    color_nxt    = color_r;
    if (in_start_of_text) begin
      cursor_x_nxt = in_origin_x;
      cursor_y_nxt = in_origin_y;
      line_x_nxt   = in_origin_x;
      color_nxt    = default_color_r;
    end
    if (is_color) begin
      color_nxt = in_text_byte;
    end else if (is_newline) begin
      cursor_x_nxt = line_x_nxt;
      cursor_y_nxt = cursor_y_nxt + YW'(LINE_PITCH);
    end
  end

  // ---- cell walk ----
  assign px          = cursor_x_r + XW'(k_r);
  assign ch_in_range = (int'(ch_r) >= tpcg_pkg::FIRST_CHAR) &&
                       (int'(ch_r) <= tpcg_pkg::LAST_CHAR);
  assign char_off    = ch_r - 8'(tpcg_pkg::FIRST_CHAR);
  assign glyph_base  = tpcg_pkg::GAW'(char_off) * tpcg_pkg::GAW'(tpcg_pkg::GLYPH_COLS);
  assign rd_addr     = AW'(glyph_base) + AW'(k_r);
  assign pix_set     = col_glyph_r && col_bits_r[row_r];

  assign sts.draw     = (in_opcode == tpcg_pkg::OP_TEXT) && !is_color && !is_newline;
  assign sts.col_end  = (int'(k_r) == CELL_WIDTH);
  assign sts.col_skip = clip_en_r && (px != clip_col_r);
  assign sts.row_last = (row_r == RW'(tpcg_pkg::GLYPH_ROWS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  // ---- config ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_limit_r   <= tpcg_pkg::RST_COLOR_LIMIT;
      default_color_r <= tpcg_pkg::RST_DEFAULT_COLOR;
      blank_color_r   <= tpcg_pkg::RST_BLANK_COLOR;
      clip_en_r       <= 1'b0;
      clip_col_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpcg_pkg::REG_COLOR_LIMIT:   color_limit_r   <= cfg_data[CW-1:0];
        tpcg_pkg::REG_DEFAULT_COLOR: default_color_r <= cfg_data[CW-1:0];
        tpcg_pkg::REG_BLANK_COLOR:   blank_color_r   <= cfg_data[CW-1:0];
        tpcg_pkg::REG_CLIP_ENABLE:   clip_en_r       <= cfg_data[0];
        tpcg_pkg::REG_CLIP_COLUMN:   clip_col_r      <= cfg_data[XW-1:0];
        default: ;
      endcase
    end
  end

  // ---- text state and walk counters ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      line_x_r   <= '0;
      color_r    <= tpcg_pkg::RST_DEFAULT_COLOR;
      k_r        <= '0;
      row_r      <= '0;
    end else begin
      if (cmd.accept && in_opcode == tpcg_pkg::OP_TEXT) begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        line_x_r   <= line_x_nxt;
        color_r    <= color_nxt;
      end
      if (cmd.done) begin
        cursor_x_r <= cursor_x_r + XW'(CELL_WIDTH);
        k_r        <= '0;
      end else if (cmd.col_adv) begin
        k_r <= k_r + KW'(1);
      end
      if (cmd.col_load) begin
        row_r <= '0;
      end else if (cmd.emit) begin
        row_r <= row_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) ch_r <= in_text_byte;
  end

  // ---- glyph store ----
  always_ff @(posedge clk) begin
    if (cmd.accept && in_opcode == tpcg_pkg::OP_GLYPH &&
        int'(in_glyph_addr) < GLYPH_STORE_DEPTH) begin
      glyph_mem[AW'(in_glyph_addr)] <= in_glyph_data;
    end
  end

  // out-of-font chars and blank cell columns never use the read word
  always_ff @(posedge clk) begin
    if (cmd.col_load) begin
      col_glyph_r <= ch_in_range && (int'(k_r) < tpcg_pkg::GLYPH_COLS);
      if (ch_in_range && int'(k_r) < tpcg_pkg::GLYPH_COLS) begin
        col_bits_r <= glyph_mem[rd_addr];
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // with clipping at most one column of a cell can match
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      px_r   <= px;
      py_r   <= cursor_y_r + YW'(row_r);
      pc_r   <= pix_set ? color_r : blank_color_r;
      last_r <= sts.row_last && (clip_en_r || int'(k_r) == CELL_WIDTH - 1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = pc_r;
  assign out_last        = last_r;

  `include "text_to_pixel_character_generator_core_macros.svh"

  `TPCG_ASSERT_NEXT(a_rise_from_emit, !out_valid_r && !cmd.emit, !out_valid_r, "output word without emit")
  `TPCG_ASSERT_NEXT(a_last_bottom, cmd.emit && !sts.row_last, !last_r, "last flag above bottom row")
  `TPCG_ASSERT_NOW(a_emit_in_cell, cmd.emit, !sts.col_end, "pixel emitted past the last cell column")

endmodule
